[design/aluf_pkg.sv]
// Shared types and constants for the ALU status flag update block.
`timescale 1ns / 1ps
`default_nettype none

package aluf_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_AND = 3'd2,
    OP_OR  = 3'd3,
    OP_MUL = 3'd4,
    OP_SHL = 3'd5,
    OP_SHR = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    WC_8  = 2'd0,
    WC_16 = 2'd1,
    WC_32 = 2'd2
  } width_code_e;

  localparam int unsigned CF_BIT = 0;
  localparam int unsigned PF_BIT = 2;
  localparam int unsigned ZF_BIT = 6;
  localparam int unsigned SF_BIT = 7;
  localparam int unsigned OF_BIT = 11;

  localparam logic [31:0] STATUS_RESET = 32'h0000_0202;
  localparam logic [31:0] FLAG_MASK    = 32'h0000_08C5;

endpackage

`default_nettype wire

[design/alu_status_flag_update_top.sv]
// Top level of the ALU status flag update block.
//
// The block keeps a 32-bit x86-style status word. Each input word carries an
// opcode, an operand size code and two operands. The block updates the carry,
// parity, zero, sign and overflow bits of the status word from that operation
// (a multiply only carry and overflow, a zero shift count none) and returns
// the whole status word as one output word. All other bits keep their value.
// Both channels use valid and stall: a word moves at a rising edge where
// valid is high and stall is low.
// An accepted word is captured in an input register, the flags are computed
// in one pass of combinational logic, and the new status word is written into
// the status register and the output register at the same edge. One word per
// cycle is sustained while the receiver does not stall.
// When the receiver stalls, the output word holds; the input register still
// takes one more word, and the input stalls only once both stages are full.
// Reset sets the status word to 0x00000202 and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module alu_status_flag_update_top
  import aluf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [1:0]  width_code_i,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      flags_word_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [2:0]  opcode_q;
  logic [1:0]  width_q;
  logic [31:0] a_q, b_q;
  logic [31:0] status_q, status_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q;
  logic        advance, in_take;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q <= opcode_i;
      width_q  <= width_code_i;
      a_q      <= operand_a_i;
      b_q      <= operand_b_i;
    end
    if (advance) begin
      out_word_q <= status_d;
    end
  end

  always_comb begin
    logic [31:0] msk;
    logic [31:0] ta, tb;
    logic [4:0]  cnt;
    logic [32:0] sum, diff;
    logic [63:0] prod, shl_w;
    logic [31:0] shr_w;
    logic [31:0] res;
    logic        res_top, a_top, a_next;
    logic        add_c, shl_c, mul_hi;
    logic        upd_res, cf, of, upd_of;

    unique case (width_q)
      WC_8:    msk = 32'h0000_00FF;
      WC_16:   msk = 32'h0000_FFFF;
      default: msk = 32'hFFFF_FFFF;
    endcase
    ta    = a_q & msk;
    tb    = b_q & msk;
    cnt   = b_q[4:0];
    sum   = {1'b0, ta} + {1'b0, tb};
    diff  = {1'b0, ta} - {1'b0, tb};
    prod  = {32'b0, ta} * {32'b0, tb};
    shl_w = {32'b0, ta} << cnt;
    shr_w = ta >> cnt;

    unique case (width_q)
      WC_8: begin
        add_c  = sum[8];
        shl_c  = shl_w[8];
        mul_hi = |prod[63:8];
        a_top  = ta[7];
        a_next = ta[6];
      end
      WC_16: begin
        add_c  = sum[16];
        shl_c  = shl_w[16];
        mul_hi = |prod[63:16];
        a_top  = ta[15];
        a_next = ta[14];
      end
      default: begin
        add_c  = sum[32];
        shl_c  = shl_w[32];
        mul_hi = |prod[63:32];
        a_top  = ta[31];
        a_next = ta[30];
      end
    endcase

    res     = '0;
    upd_res = 1'b0;
    cf      = status_q[CF_BIT];
    of      = status_q[OF_BIT];
    upd_of  = 1'b0;

    unique case (opcode_q)
      OP_ADD: begin
        res     = sum[31:0] & msk;
        upd_res = 1'b1;
        cf      = add_c;
        upd_of  = 1'b1;
      end
      OP_SUB: begin
        res     = diff[31:0] & msk;
        upd_res = 1'b1;
        cf      = diff[32];
        upd_of  = 1'b1;
      end
      OP_AND: begin
        res     = ta & tb;
        upd_res = 1'b1;
        cf      = 1'b0;
        of      = 1'b0;
      end
      OP_OR: begin
        res     = ta | tb;
        upd_res = 1'b1;
        cf      = 1'b0;
        of      = 1'b0;
      end
      OP_MUL: begin
        cf = mul_hi;
        of = mul_hi;
      end
      OP_SHL: begin
        if (cnt != 5'd0) begin
          res     = shl_w[31:0] & msk;
          upd_res = 1'b1;
          cf      = shl_c;
          if (cnt == 5'd1) begin
            of = a_top ^ a_next;
          end
        end
      end
      OP_SHR: begin
        if (cnt != 5'd0) begin
          res     = shr_w;
          upd_res = 1'b1;
          cf      = ta[cnt - 5'd1];
          if (cnt == 5'd1) begin
            of = a_top;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase

    unique case (width_q)
      WC_8:    res_top = res[7];
      WC_16:   res_top = res[15];
      default: res_top = res[31];
    endcase

    if (upd_of) begin
      if (opcode_q == OP_ADD) begin
        of = ((~(ta ^ tb) & (ta ^ res) & (msk ^ (msk >> 1))) != 32'd0);
      end else begin
        of = (((ta ^ tb) & (ta ^ res) & (msk ^ (msk >> 1))) != 32'd0);
      end
    end

    status_d         = status_q;
    status_d[CF_BIT] = cf;
    status_d[OF_BIT] = of;
    if (upd_res) begin
      status_d[PF_BIT] = ~(^res[7:0]);
      status_d[ZF_BIT] = (res == 32'd0);
      status_d[SF_BIT] = res_top;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign flags_word_o = out_word_q;

endmodule

`default_nettype wire

[design/aluf_checker.sv]
// Port-level checker for the ALU status flag update block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module aluf_checker
  import aluf_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] flags_word_o
);

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(flags_word_o))
    else $error("output word changed while stalled");

  // Bits outside the arithmetic flags never leave their reset value.
  a_other_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((flags_word_o & ~FLAG_MASK) == STATUS_RESET))
    else $error("status bit outside the arithmetic flags changed");

  // A zero result has even parity and a clear sign bit.
  a_zero_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flags_word_o[ZF_BIT] |->
      flags_word_o[PF_BIT] && !flags_word_o[SF_BIT])
    else $error("zero flag set with odd parity or negative sign");

  // The input side is never stalled while the output side is free.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output register");

endmodule

bind alu_status_flag_update_top aluf_checker u_aluf_checker (.*);

`default_nettype wire

[sim/alu_status_flag_update_checker.sv]
// Monitor that predicts the status word for each accepted input word and checks the output.
`timescale 1ns / 1ps

module alu_status_flag_update_checker
  import aluf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_stall_i,
  input  wire logic [2:0]   opcode_i,
  input  wire logic [1:0]   width_code_i,
  input  wire logic [31:0]  operand_a_i,
  input  wire logic [31:0]  operand_b_i,
  input  wire logic         out_valid_i,
  input  wire logic         out_stall_i,
  input  wire logic [31:0]  flags_word_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);

  logic [31:0] status_shadow;
  logic [31:0] expected_words[$];

  function automatic logic [31:0] next_status_word(input logic [31:0] word,
                                                   input logic [2:0]  op,
                                                   input logic [1:0]  wc,
                                                   input logic [31:0] a,
                                                   input logic [31:0] b);
    int unsigned nbits;
    logic [31:0] msk;
    logic [31:0] top;
    logic [31:0] ta;
    logic [31:0] tb;
    logic [31:0] res;
    logic [4:0]  cnt;
    logic [32:0] sum;
    logic [63:0] wide;
    logic        res_flags;
    case (wc)
      WC_8:    nbits = 8;
      WC_16:   nbits = 16;
      default: nbits = 32;
    endcase
    msk = (nbits == 32) ? 32'hffff_ffff : ((32'd1 << nbits) - 32'd1);
    top = 32'd1 << (nbits - 1);
    ta = a & msk;
    tb = b & msk;
    cnt = b[4:0];
    res = '0;
    res_flags = 1'b0;
    case (op)
      OP_ADD: begin
        sum = {1'b0, ta} + {1'b0, tb};
        res = sum[31:0] & msk;
        res_flags = 1'b1;
        word[CF_BIT] = sum[nbits];
        word[OF_BIT] = |(~(ta ^ tb) & (ta ^ res) & top);
      end
      OP_SUB: begin
        res = (ta - tb) & msk;
        res_flags = 1'b1;
        word[CF_BIT] = ta < tb;
        word[OF_BIT] = |((ta ^ tb) & (ta ^ res) & top);
      end
      OP_AND, OP_OR: begin
        res = (op == OP_AND) ? (ta & tb) : (ta | tb);
        res_flags = 1'b1;
        word[CF_BIT] = 1'b0;
        word[OF_BIT] = 1'b0;
      end
      OP_MUL: begin
        wide = {32'd0, ta} * {32'd0, tb};
        word[CF_BIT] = |(wide >> nbits);
        word[OF_BIT] = |(wide >> nbits);
      end
      OP_SHL: begin
        if (cnt != 5'd0) begin
          wide = {32'd0, ta} << cnt;
          res = wide[31:0] & msk;
          res_flags = 1'b1;
          word[CF_BIT] = wide[nbits];
          if (cnt == 5'd1) begin
            word[OF_BIT] = ta[nbits - 1] ^ ta[nbits - 2];
          end
        end
      end
      OP_SHR: begin
        if (cnt != 5'd0) begin
          res = ta >> cnt;
          res_flags = 1'b1;
          word[CF_BIT] = ta[cnt - 1];
          if (cnt == 5'd1) begin
            word[OF_BIT] = ta[nbits - 1];
          end
        end
      end
      default: begin
      end
    endcase
    if (res_flags) begin
      word[PF_BIT] = ~^res[7:0];
      word[ZF_BIT] = (res == 32'd0);
      word[SF_BIT] = |(res & top);
    end
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      status_shadow = STATUS_RESET;
      expected_words.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("flags_word: unexpected word, expected none, actual %h", flags_word_i);
          mismatch_count_o = mismatch_count_o + 1;
        end else begin
          want = expected_words.pop_front();
          if (flags_word_i !== want) begin
            $error("flags_word: expected %h, actual %h", want, flags_word_i);
            mismatch_count_o = mismatch_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        status_shadow = next_status_word(status_shadow, opcode_i, width_code_i,
                                         operand_a_i, operand_b_i);
        expected_words.push_back(status_shadow);
      end
      pending_o = expected_words.size();
    end
  end

endmodule

[sim/tb_alu_status_flag_update_top.sv]
// Testbench top for the ALU status flag update block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_alu_status_flag_update_top;
  import aluf_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [1:0] WC_UNUSED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned HOLD_CYCLES = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i = OP_ADD;
  logic [1:0]  width_code_i = WC_8;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] flags_word_o;

  int unsigned mismatch_count;
  int unsigned pending_words;
  logic        in_fire;
  logic        calm = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;

  always #5 clk_i = ~clk_i;

  alu_status_flag_update_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .width_code_i (width_code_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .flags_word_o (flags_word_o)
  );

  alu_status_flag_update_checker i_flag_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .opcode_i         (opcode_i),
    .width_code_i     (width_code_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .flags_word_i     (flags_word_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_words)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (holds_done < hold_requests) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done = holds_done + 1;
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 30);
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned size_bits(input logic [1:0] wc);
    case (wc)
      WC_8:    return 8;
      WC_16:   return 16;
      default: return 32;
    endcase
  endfunction

  function automatic logic [31:0] random_operand(input logic [1:0] wc);
    int unsigned nbits;
    logic [31:0] msk;
    logic [31:0] value;
    nbits = size_bits(wc);
    msk = (nbits == 32) ? 32'hffff_ffff : ((32'd1 << nbits) - 32'd1);
    case ($urandom_range(0, 9))
      0:       value = '0;
      1:       value = msk;
      2:       value = 32'd1 << (nbits - 1);
      3:       value = msk >> 1;
      4:       value = $urandom_range(0, 3);
      default: value = $urandom;
    endcase
    if ($urandom_range(0, 1) == 1) begin
      value = (value & msk) | ($urandom & ~msk);
    end
    return value;
  endfunction

  function automatic logic [31:0] random_count(input logic [1:0] wc);
    int unsigned nbits;
    logic [4:0]  cnt;
    nbits = size_bits(wc);
    case ($urandom_range(0, 7))
      0:       cnt = 5'd0;
      1:       cnt = 5'd1;
      2:       cnt = 5'(nbits - 1);
      3:       cnt = 5'(nbits);
      4:       cnt = 5'(nbits + 1);
      default: cnt = 5'($urandom_range(0, 31));
    endcase
    return {$urandom} & 32'hffff_ffe0 | {27'd0, cnt};
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [1:0] wc,
                           input logic [31:0] a, input logic [31:0] b);
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    width_code_i <= wc;
    operand_a_i  <= a;
    operand_b_i  <= b;
    do @(negedge clk_i); while (!in_fire);
  endtask

  task automatic send_random_word();
    logic [2:0]  op;
    logic [1:0]  wc;
    logic [31:0] a;
    logic [31:0] b;
    op = 3'($urandom_range(0, 6));
    wc = 2'($urandom_range(0, 2));
    a = random_operand(wc);
    if (op == OP_SHL || op == OP_SHR) begin
      b = random_count(wc);
    end else if (op == OP_SUB && $urandom_range(0, 9) == 0) begin
      b = a;
    end else begin
      b = random_operand(wc);
    end
    send_word(op, wc, a, b);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_word(OP_ADD, WC_8,  32'h0000_007f, 32'h0000_0001);
    send_word(OP_ADD, WC_8,  32'hffff_ffff, 32'h1234_5601);
    send_word(OP_ADD, WC_32, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_SUB, WC_16, 32'h0000_0000, 32'h0000_0001);
    send_word(OP_SUB, WC_32, 32'h8000_0000, 32'h0000_0001);
    send_word(OP_SUB, WC_32, 32'hdead_beef, 32'hdead_beef);
    send_word(OP_AND, WC_32, 32'hffff_0000, 32'h0000_ffff);
    send_word(OP_OR,  WC_16, 32'h5555_8001, 32'haaaa_0000);
    send_word(OP_MUL, WC_8,  32'h0000_00ff, 32'h0000_00ff);
    send_word(OP_MUL, WC_16, 32'hffff_0010, 32'hffff_0010);
    send_word(OP_MUL, WC_32, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_MUL, WC_32, 32'h0001_0000, 32'h0000_ffff);
    send_word(OP_SHL, WC_8,  32'h0000_0040, 32'h0000_0001);
    send_word(OP_SHL, WC_8,  32'h0000_00ff, 32'hffff_ffe0);
    send_word(OP_SHL, WC_8,  32'h0000_0001, 32'h0000_0008);
    send_word(OP_SHL, WC_8,  32'h0000_00ff, 32'h0000_0009);
    send_word(OP_SHL, WC_32, 32'h0000_0003, 32'h0000_001f);
    send_word(OP_SHR, WC_16, 32'h0000_8000, 32'h0000_0001);
    send_word(OP_SHR, WC_16, 32'h0000_8001, 32'hffff_ffe1);
    send_word(OP_SHR, WC_8,  32'hffff_ffff, 32'h0000_0014);
    send_word(OP_SHR, WC_32, 32'hffff_ffff, 32'h0000_0000);
    send_word(OP_SHR, WC_32, 32'h8000_0000, 32'h0000_001f);
    send_word(OP_UNUSED, WC_32, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_ADD, WC_UNUSED, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_SUB, WC_UNUSED, 32'h0000_0001, 32'h0000_0002);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= 300 && i < 420);
      if (i == 150 || i == 650) begin
        hold_requests = hold_requests + 1;
      end
      if (i == 500) begin
        in_valid_i <= 1'b0;
        wait (pending_words == 0);
        @(negedge clk_i);
      end
      send_random_word();
    end
    in_valid_i <= 1'b0;

    wait (pending_words == 0);
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
